[rtl/core/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// rtc_pkg
// shared types and constants of the rigid transform composer
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int QUAT_W     = 16;
    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_STAGES = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_X   = 3'd0,
        CFG_ROT_Y   = 3'd1,
        CFG_ROT_Z   = 3'd2,
        CFG_ROT_W   = 3'd3,
        CFG_SHIFT_X = 3'd4,
        CFG_SHIFT_Y = 3'd5,
        CFG_SHIFT_Z = 3'd6
    } t_cfg_idx;

    typedef logic signed [QUAT_W-1:0] t_quat_comp;
    typedef logic signed [POS_W-1:0]  t_pos;

    typedef struct packed {
        t_quat_comp x;
        t_quat_comp y;
        t_quat_comp z;
        t_quat_comp w;
    } t_quat;

    typedef struct packed {
        t_pos x;
        t_pos y;
        t_pos z;
    } t_vec;

    // per-stage load strobes from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } t_pipe_ctl;

endpackage

[rtl/core/rigid_transform_compose.sv]
// ----------------------------------------------------------------------------
// rigid_transform_compose
// composes a configured rigid transform with a streamed quaternion and point
// each request moves through the four-stage multiply pipeline to the output
// throughput: one request per cycle unless a stalled result fills the stages
// reset: synchronous, clears all stage valids; rotation returns to identity
// and translation to zero
// ----------------------------------------------------------------------------
module rigid_transform_compose
    import rtc_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [15:0]    i_in_quat_x,
    input  logic signed [15:0]    i_in_quat_y,
    input  logic signed [15:0]    i_in_quat_z,
    input  logic signed [15:0]    i_in_quat_w,
    input  logic signed [31:0]    i_point_x,
    input  logic signed [31:0]    i_point_y,
    input  logic signed [31:0]    i_point_z,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [15:0]    o_out_quat_x,
    output logic signed [15:0]    o_out_quat_y,
    output logic signed [15:0]    o_out_quat_z,
    output logic signed [15:0]    o_out_quat_w,
    output logic signed [31:0]    o_out_point_x,
    output logic signed [31:0]    o_out_point_y,
    output logic signed [31:0]    o_out_point_z
);

    // identity scalar, clipped when one does not fit in the 16-bit format
    localparam t_quat_comp ROT_W_RST = (QUAT_FRAC_BITS >= QUAT_W - 1)
        ? t_quat_comp'(32767) : t_quat_comp'(longint'(1) << QUAT_FRAC_BITS);

    t_quat     r_rot;
    t_vec      r_shift;
    t_pipe_ctl ctl;
    t_quat     in_quat;
    t_vec      in_point;
    t_quat     res_quat;
    t_vec      res_point;

    // configuration registers, written by the user only while no request is
    // in flight (not enforced here), so all stages may read them live
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.x   <= '0;
            r_rot.y   <= '0;
            r_rot.z   <= '0;
            r_rot.w   <= ROT_W_RST;
            r_shift.x <= '0;
            r_shift.y <= '0;
            r_shift.z <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_X:   r_rot.x   <= i_cfg_data[QUAT_W-1:0];
                CFG_ROT_Y:   r_rot.y   <= i_cfg_data[QUAT_W-1:0];
                CFG_ROT_Z:   r_rot.z   <= i_cfg_data[QUAT_W-1:0];
                CFG_ROT_W:   r_rot.w   <= i_cfg_data[QUAT_W-1:0];
                CFG_SHIFT_X: r_shift.x <= i_cfg_data[POS_W-1:0];
                CFG_SHIFT_Y: r_shift.y <= i_cfg_data[POS_W-1:0];
                CFG_SHIFT_Z: r_shift.z <= i_cfg_data[POS_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // bundle the request fields
    assign in_quat.x  = i_in_quat_x;
    assign in_quat.y  = i_in_quat_y;
    assign in_quat.z  = i_in_quat_z;
    assign in_quat.w  = i_in_quat_w;
    assign in_point.x = i_point_x;
    assign in_point.y = i_point_y;
    assign in_point.z = i_point_z;

    // stage valids and load strobes; a stalled result only holds back the
    // stages behind it that are already full
    rtc_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    // rotation: products, sums, round/saturate, output register
    rtc_quat #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_quat (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_rot  (r_rot),
        .i_quat (in_quat),
        .o_quat (res_quat)
    );

    // point path: qv x p products, rounded a, qv x a products, final sum
    rtc_point #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_point (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_rot   (r_rot),
        .i_shift (r_shift),
        .i_point (in_point),
        .o_point (res_point)
    );

    assign o_out_quat_x  = res_quat.x;
    assign o_out_quat_y  = res_quat.y;
    assign o_out_quat_z  = res_quat.z;
    assign o_out_quat_w  = res_quat.w;
    assign o_out_point_x = res_point.x;
    assign o_out_point_y = res_point.y;
    assign o_out_point_z = res_point.z;

endmodule

[rtl/core/rtc_ctl.sv]
// ----------------------------------------------------------------------------
// rtc_ctl
// valid tracking and per-stage load control, bubbles collapse on stall
// ----------------------------------------------------------------------------
module rtc_ctl
    import rtc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] stage_ld;

    // a stage loads when empty or when the stage after it moves
    assign stage_ld[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
    for (genvar k = 0; k < NUM_STAGES-1; k++) begin : g_ld
        assign stage_ld[k] = !r_vld[k] || stage_ld[k+1];
    end

    assign n_vld = (stage_ld & {r_vld[NUM_STAGES-2:0], i_in_valid})
                 | (~stage_ld & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = stage_ld[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_ctl.ld    = stage_ld;

endmodule

[rtl/core/rtc_quat.sv]
// ----------------------------------------------------------------------------
// rtc_quat
// hamilton product of fixed and input quaternion, round and saturate
// ----------------------------------------------------------------------------
module rtc_quat
    import rtc_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_quat     i_rot,
    input  t_quat     i_quat,
    output t_quat     o_quat
);

    localparam int PROD_W = 2 * QUAT_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam logic signed [SUM_W-1:0] HALF  =
        SUM_W'(longint'(1) << (QUAT_FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] Q_MIN = SUM_W'(-32768);

    logic signed [PROD_W-1:0] r_m [16];
    logic signed [SUM_W-1:0]  r_sum [4];
    t_quat                    r_q;
    t_quat                    r_q_out;

    function automatic t_quat_comp sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] sh;
        sh = v >>> QUAT_FRAC_BITS;
        if (sh > Q_MAX) begin
            return t_quat_comp'(Q_MAX);
        end else if (sh < Q_MIN) begin
            return t_quat_comp'(Q_MIN);
        end
        return sh[QUAT_W-1:0];
    endfunction

    // stage 0: sixteen partial products
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_m[0]  <= PROD_W'($signed(i_rot.w)) * PROD_W'($signed(i_quat.x));
            r_m[1]  <= PROD_W'($signed(i_rot.x)) * PROD_W'($signed(i_quat.w));
            r_m[2]  <= PROD_W'($signed(i_rot.y)) * PROD_W'($signed(i_quat.z));
            r_m[3]  <= PROD_W'($signed(i_rot.z)) * PROD_W'($signed(i_quat.y));
            r_m[4]  <= PROD_W'($signed(i_rot.w)) * PROD_W'($signed(i_quat.y));
            r_m[5]  <= PROD_W'($signed(i_rot.x)) * PROD_W'($signed(i_quat.z));
            r_m[6]  <= PROD_W'($signed(i_rot.y)) * PROD_W'($signed(i_quat.w));
            r_m[7]  <= PROD_W'($signed(i_rot.z)) * PROD_W'($signed(i_quat.x));
            r_m[8]  <= PROD_W'($signed(i_rot.w)) * PROD_W'($signed(i_quat.z));
            r_m[9]  <= PROD_W'($signed(i_rot.x)) * PROD_W'($signed(i_quat.y));
            r_m[10] <= PROD_W'($signed(i_rot.y)) * PROD_W'($signed(i_quat.x));
            r_m[11] <= PROD_W'($signed(i_rot.z)) * PROD_W'($signed(i_quat.w));
            r_m[12] <= PROD_W'($signed(i_rot.w)) * PROD_W'($signed(i_quat.w));
            r_m[13] <= PROD_W'($signed(i_rot.x)) * PROD_W'($signed(i_quat.x));
            r_m[14] <= PROD_W'($signed(i_rot.y)) * PROD_W'($signed(i_quat.y));
            r_m[15] <= PROD_W'($signed(i_rot.z)) * PROD_W'($signed(i_quat.z));
        end
    end

    // stage 1: exact sums with the rounding half
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[1]) begin
            r_sum[0] <= SUM_W'(r_m[0]) + SUM_W'(r_m[1]) + SUM_W'(r_m[2])
                      - SUM_W'(r_m[3]) + HALF;
            r_sum[1] <= SUM_W'(r_m[4]) - SUM_W'(r_m[5]) + SUM_W'(r_m[6])
                      + SUM_W'(r_m[7]) + HALF;
            r_sum[2] <= SUM_W'(r_m[8]) + SUM_W'(r_m[9]) - SUM_W'(r_m[10])
                      + SUM_W'(r_m[11]) + HALF;
            r_sum[3] <= SUM_W'(r_m[12]) - SUM_W'(r_m[13]) - SUM_W'(r_m[14])
                      - SUM_W'(r_m[15]) + HALF;
        end
    end

    // stage 2: shift and saturate
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[2]) begin
            r_q.x <= sat_q(r_sum[0]);
            r_q.y <= sat_q(r_sum[1]);
            r_q.z <= sat_q(r_sum[2]);
            r_q.w <= sat_q(r_sum[3]);
        end
    end

    // stage 3: aligned with the point path
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[3]) begin
            r_q_out <= r_q;
        end
    end

    assign o_quat = r_q_out;

endmodule

[rtl/core/rtc_point.sv]
// ----------------------------------------------------------------------------
// rtc_point
// point rotation by doubled cross products plus fixed translation
// ----------------------------------------------------------------------------
module rtc_point
    import rtc_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_quat     i_rot,
    input  t_vec      i_shift,
    input  t_vec      i_point,
    output t_vec      o_point
);

    localparam int PROD_W = QUAT_W + POS_W;
    localparam int S_W    = PROD_W + 3;
    localparam int A_W    = S_W - QUAT_FRAC_BITS;
    localparam int C_W    = QUAT_W + A_W;
    localparam int B_W    = POS_W + 1 + QUAT_FRAC_BITS;
    localparam int R_W    = ((B_W > C_W + 1) ? B_W : (C_W + 1)) + 2;
    localparam logic signed [S_W-1:0] S_HALF =
        S_W'(longint'(1) << (QUAT_FRAC_BITS - 1));
    localparam logic signed [R_W-1:0] R_HALF =
        R_W'(longint'(1) << (QUAT_FRAC_BITS - 1));
    localparam logic signed [R_W-1:0] P_MAX = R_W'(64'sd2147483647);
    localparam logic signed [R_W-1:0] P_MIN = R_W'(-64'sd2147483648);

    logic signed [PROD_W-1:0] r_m [9];
    logic signed [POS_W:0]    r_ps [3];
    logic signed [POS_W:0]    r_ps2 [3];
    logic signed [A_W-1:0]    r_a [3];
    logic signed [C_W-1:0]    r_c [6];
    logic signed [R_W-1:0]    r_base [3];
    t_vec                     r_p_out;

    logic signed [S_W-1:0]    a_sum_x, a_sum_y, a_sum_z;
    logic signed [R_W-1:0]    r_sum_x, r_sum_y, r_sum_z;

    function automatic t_pos sat_p(input logic signed [R_W-1:0] v);
        logic signed [R_W-1:0] sh;
        sh = v >>> QUAT_FRAC_BITS;
        if (sh > P_MAX) begin
            return t_pos'(P_MAX);
        end else if (sh < P_MIN) begin
            return t_pos'(P_MIN);
        end
        return sh[POS_W-1:0];
    endfunction

    // stage 0: rotation by point products and p + s
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_m[0] <= PROD_W'($signed(i_rot.y)) * PROD_W'($signed(i_point.z));
            r_m[1] <= PROD_W'($signed(i_rot.z)) * PROD_W'($signed(i_point.y));
            r_m[2] <= PROD_W'($signed(i_rot.w)) * PROD_W'($signed(i_point.x));
            r_m[3] <= PROD_W'($signed(i_rot.z)) * PROD_W'($signed(i_point.x));
            r_m[4] <= PROD_W'($signed(i_rot.x)) * PROD_W'($signed(i_point.z));
            r_m[5] <= PROD_W'($signed(i_rot.w)) * PROD_W'($signed(i_point.y));
            r_m[6] <= PROD_W'($signed(i_rot.x)) * PROD_W'($signed(i_point.y));
            r_m[7] <= PROD_W'($signed(i_rot.y)) * PROD_W'($signed(i_point.x));
            r_m[8] <= PROD_W'($signed(i_rot.w)) * PROD_W'($signed(i_point.z));
            r_ps[0] <= (POS_W+1)'($signed(i_point.x)) + (POS_W+1)'($signed(i_shift.x));
            r_ps[1] <= (POS_W+1)'($signed(i_point.y)) + (POS_W+1)'($signed(i_shift.y));
            r_ps[2] <= (POS_W+1)'($signed(i_point.z)) + (POS_W+1)'($signed(i_shift.z));
        end
    end

    // a = round(2 * (qv x p + w * p))
    assign a_sum_x = ((S_W'(r_m[0]) - S_W'(r_m[1]) + S_W'(r_m[2])) <<< 1) + S_HALF;
    assign a_sum_y = ((S_W'(r_m[3]) - S_W'(r_m[4]) + S_W'(r_m[5])) <<< 1) + S_HALF;
    assign a_sum_z = ((S_W'(r_m[6]) - S_W'(r_m[7]) + S_W'(r_m[8])) <<< 1) + S_HALF;

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[1]) begin
            r_a[0]   <= A_W'(a_sum_x >>> QUAT_FRAC_BITS);
            r_a[1]   <= A_W'(a_sum_y >>> QUAT_FRAC_BITS);
            r_a[2]   <= A_W'(a_sum_z >>> QUAT_FRAC_BITS);
            r_ps2[0] <= r_ps[0];
            r_ps2[1] <= r_ps[1];
            r_ps2[2] <= r_ps[2];
        end
    end

    // stage 2: qv x a products and scaled translated point
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[2]) begin
            r_c[0] <= C_W'($signed(i_rot.y)) * C_W'(r_a[2]);
            r_c[1] <= C_W'($signed(i_rot.z)) * C_W'(r_a[1]);
            r_c[2] <= C_W'($signed(i_rot.z)) * C_W'(r_a[0]);
            r_c[3] <= C_W'($signed(i_rot.x)) * C_W'(r_a[2]);
            r_c[4] <= C_W'($signed(i_rot.x)) * C_W'(r_a[1]);
            r_c[5] <= C_W'($signed(i_rot.y)) * C_W'(r_a[0]);
            r_base[0] <= (R_W'(r_ps2[0]) <<< QUAT_FRAC_BITS) + R_HALF;
            r_base[1] <= (R_W'(r_ps2[1]) <<< QUAT_FRAC_BITS) + R_HALF;
            r_base[2] <= (R_W'(r_ps2[2]) <<< QUAT_FRAC_BITS) + R_HALF;
        end
    end

    assign r_sum_x = r_base[0] + R_W'(r_c[0]) - R_W'(r_c[1]);
    assign r_sum_y = r_base[1] + R_W'(r_c[2]) - R_W'(r_c[3]);
    assign r_sum_z = r_base[2] + R_W'(r_c[4]) - R_W'(r_c[5]);

    // stage 3: final sum, shift and saturate
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[3]) begin
            r_p_out.x <= sat_p(r_sum_x);
            r_p_out.y <= sat_p(r_sum_y);
            r_p_out.z <= sat_p(r_sum_z);
        end
    end

    assign o_point = r_p_out;

endmodule

[rtl/core/rtc_checker.sv]
// ----------------------------------------------------------------------------
// rtc_checker
// port-level checks of the rigid transform composer
// ----------------------------------------------------------------------------
module rtc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_out_quat_x,
    input logic signed [15:0] i_out_quat_y,
    input logic signed [15:0] i_out_quat_z,
    input logic signed [15:0] i_out_quat_w,
    input logic signed [31:0] i_out_point_x,
    input logic signed [31:0] i_out_point_y,
    input logic signed [31:0] i_out_point_z
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // an empty output stage means every stage can load
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request refused with an empty output stage");

    // an accepted request reaches a valid result while the result side keeps taking
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid)
        else $error("result missing four cycles after request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
        && $stable(i_out_quat_x) && $stable(i_out_quat_y)
        && $stable(i_out_quat_z) && $stable(i_out_quat_w)
        && $stable(i_out_point_x) && $stable(i_out_point_y)
        && $stable(i_out_point_z))
        else $error("stalled result changed");

endmodule

bind rigid_transform_compose rtc_checker u_rtc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .i_in_ready    (o_in_ready),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_out_quat_x  (o_out_quat_x),
    .i_out_quat_y  (o_out_quat_y),
    .i_out_quat_z  (o_out_quat_z),
    .i_out_quat_w  (o_out_quat_w),
    .i_out_point_x (o_out_point_x),
    .i_out_point_y (o_out_point_y),
    .i_out_point_z (o_out_point_z)
);
